// ----- design/bgsh_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and helper functions for the bernoulli gate sample-hold block
// no dependencies
package bgsh_pkg;

    localparam int MaxChannels = 16;
    localparam int ChanW       = $clog2(MaxChannels);
    localparam int CountW      = 5;
    localparam int RandomBits  = 16;
    localparam int QueueDepth  = 2;
    localparam int QueuePtrW   = $clog2(QueueDepth);

    localparam int ThreshLimit = 5000;
    localparam int CoinScale   = 2 * ThreshLimit;
    localparam int CoinBias    = ThreshLimit * (1 << RandomBits);
    localparam int GateLatchedMv = 10000;
    localparam int OutMax      = 16383;
    localparam int OutMin      = -16384;

    localparam logic [31:0] SeedReset = 32'd1;

    typedef enum logic [2:0] {
        RegChannelCount = 3'd0,
        RegChanceLevel  = 3'd1,
        RegCvScale      = 3'd2,
        RegCvOffset     = 3'd3,
        RegLatchMode    = 3'd4,
        RegTriggerHigh  = 3'd5,
        RegTriggerLow   = 3'd6,
        RegRandomSeed   = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [CountW-1:0]  channel_count;
        logic signed [10:0] chance_level;
        logic [13:0]        cv_scale;
        logic signed [13:0] cv_offset;
        logic               latch_mode;
        logic signed [14:0] trigger_high;
        logic signed [14:0] trigger_low;
    } cfg_t;

    typedef struct packed {
        logic        load;
        logic [31:0] value;
    } seed_load_t;

    typedef struct packed {
        logic signed [14:0] clk;
        logic signed [13:0] thresh;
        logic               fire;
    } job_t;

    typedef struct packed {
        logic [ChanW-1:0]   channel;
        logic signed [14:0] a_gate;
        logic signed [14:0] b_gate;
        logic signed [14:0] a_rand;
        logic signed [14:0] b_rand;
        logic signed [14:0] every_rand;
        logic signed [14:0] clk;
        logic               last;
    } result_t;

    function automatic logic [31:0] xorshift(input logic [31:0] s);
        logic [31:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

    function automatic logic [ChanW-1:0] last_index(input logic [CountW-1:0] cnt);
        logic [ChanW-1:0] r;
        if (cnt == '0) begin
            r = '0;
        end else if (cnt > CountW'(MaxChannels)) begin
            r = ChanW'(MaxChannels - 1);
        end else begin
            r = ChanW'(cnt - CountW'(1));
        end
        return r;
    endfunction

    function automatic logic signed [14:0] gate_mv(input logic active, input logic latch,
                                                    input logic signed [14:0] clk);
        logic signed [14:0] r;
        if (!active) begin
            r = '0;
        end else if (latch) begin
            r = 15'(GateLatchedMv);
        end else begin
            r = clk;
        end
        return r;
    endfunction

    function automatic logic signed [14:0] sat15(input logic signed [15:0] v);
        logic signed [14:0] r;
        if (v > 16'(OutMax)) begin
            r = 15'(OutMax);
        end else if (v < 16'(OutMin)) begin
            r = 15'(OutMin);
        end else begin
            r = v[14:0];
        end
        return r;
    endfunction

endpackage

// ----- design/bgsh_front.sv -----
`timescale 1ns / 1ps
// front end: schmitt trigger on the clock voltage and clamped chance threshold per tick
// depends on bgsh_pkg
module bgsh_front import bgsh_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [14:0] clock_mv,
    input  logic signed [14:0] chance_cv_mv,
    input  logic               queue_full,
    output logic               push,
    output job_t               job
);

    logic               trig_high_reg;
    logic               trig_high_next;
    logic               fire;
    logic signed [17:0] thresh_raw;
    logic signed [13:0] thresh;

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    always_comb begin
        trig_high_next = trig_high_reg;
        fire           = 1'b0;
        if (trig_high_reg) begin
            if (clock_mv <= cfg.trigger_low) begin
                trig_high_next = 1'b0;
            end
        end else if (clock_mv >= cfg.trigger_high) begin
            trig_high_next = 1'b1;
            fire           = 1'b1;
        end
    end

    always_comb begin
        thresh_raw = 18'(cfg.chance_level) * 18'sd5 + 18'(chance_cv_mv);
        if (thresh_raw > 18'(ThreshLimit)) begin
            thresh = 14'(ThreshLimit);
        end else if (thresh_raw < -18'(ThreshLimit)) begin
            thresh = -14'(ThreshLimit);
        end else begin
            thresh = thresh_raw[13:0];
        end
    end

    assign job.clk    = clock_mv;
    assign job.thresh = thresh;
    assign job.fire   = fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_high_reg <= 1'b1;
        end else if (push) begin
            trig_high_reg <= trig_high_next;
        end
    end

endmodule

// ----- design/bgsh_queue.sv -----
`timescale 1ns / 1ps
// short job queue between the front end and the channel back end
// depends on bgsh_pkg
module bgsh_queue import bgsh_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic valid,
    output job_t head
);

    localparam int CntW = $clog2(QueueDepth + 1);

    job_t                 slot_reg [QueueDepth];
    logic [QueuePtrW-1:0] wr_ptr_reg;
    logic [QueuePtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0]      count_reg;
    logic [CntW-1:0]      count_next;

    assign full  = count_reg == CntW'(QueueDepth);
    assign valid = count_reg != '0;
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CntW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QueuePtrW'(QueueDepth - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QueuePtrW'(QueueDepth - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- design/bgsh_back.sv -----
`timescale 1ns / 1ps
// back end: walks the channels of one tick, draws and routes random values,
// holds per-channel state and scales the outputs through a three-stage pipeline
// depends on bgsh_pkg
module bgsh_back import bgsh_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  seed_load_t seed,
    input  logic       job_valid,
    input  job_t       job,
    output logic       job_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_res
);

    logic                   busy_reg;
    logic [ChanW-1:0]       chan_reg;
    job_t                   job_reg;
    logic [31:0]            rng_reg;
    logic [MaxChannels-1:0] route_a_reg;
    logic [MaxChannels-1:0] route_b_reg;
    logic [RandomBits-1:0]  held_a_reg [MaxChannels];
    logic [RandomBits-1:0]  held_b_reg [MaxChannels];
    logic [RandomBits-1:0]  held_e_reg [MaxChannels];

    logic                   adv;
    logic                   issue;
    logic                   last;
    logic [31:0]            s1;
    logic [31:0]            s2;
    logic [RandomBits-1:0]  coin;
    logic [RandomBits-1:0]  rv;
    logic [31:0]            coin_x;
    logic signed [31:0]     lhs;
    logic signed [31:0]     rhs;
    logic                   pick_b;
    logic                   a_new;
    logic                   b_new;
    logic [RandomBits-1:0]  ua_new;
    logic [RandomBits-1:0]  ub_new;
    logic [RandomBits-1:0]  ue_new;

    logic                   p1_valid_reg;
    logic [ChanW-1:0]       p1_chan_reg;
    logic                   p1_last_reg;
    logic signed [14:0]     p1_a_gate_reg;
    logic signed [14:0]     p1_b_gate_reg;
    logic signed [14:0]     p1_clk_reg;
    logic [RandomBits-1:0]  p1_ua_reg;
    logic [RandomBits-1:0]  p1_ub_reg;
    logic [RandomBits-1:0]  p1_ue_reg;

    logic                   p2_valid_reg;
    logic [ChanW-1:0]       p2_chan_reg;
    logic                   p2_last_reg;
    logic signed [14:0]     p2_a_gate_reg;
    logic signed [14:0]     p2_b_gate_reg;
    logic signed [14:0]     p2_clk_reg;
    logic [13:0]            p2_pa_reg;
    logic [13:0]            p2_pb_reg;
    logic [13:0]            p2_pe_reg;

    logic                   m_valid_reg;
    result_t                m_res_reg;

    logic [RandomBits+13:0] prod_a;
    logic [RandomBits+13:0] prod_b;
    logic [RandomBits+13:0] prod_e;

    assign adv     = !m_valid_reg || out_ready;
    assign issue   = busy_reg && adv;
    assign last    = chan_reg == last_index(cfg.channel_count);
    assign job_pop = job_valid && (!busy_reg || (issue && last));

    // two draws per channel: coin first, then the sample
    always_comb begin
        s1     = xorshift(rng_reg);
        s2     = xorshift(s1);
        coin   = s1[31 -: RandomBits];
        rv     = s2[31 -: RandomBits];
        coin_x = 32'(coin) * 32'(CoinScale);
        lhs    = $signed(coin_x) - $signed(32'(CoinBias));
        rhs    = $signed(32'(job_reg.thresh)) <<< RandomBits;
        pick_b = lhs > rhs;
    end

    always_comb begin
        a_new  = route_a_reg[chan_reg];
        b_new  = route_b_reg[chan_reg];
        ua_new = held_a_reg[chan_reg];
        ub_new = held_b_reg[chan_reg];
        ue_new = held_e_reg[chan_reg];
        if (job_reg.fire) begin
            ue_new = rv;
            if (pick_b) begin
                if (!route_b_reg[chan_reg] || !cfg.latch_mode) begin
                    ub_new = rv;
                end
                a_new = 1'b0;
                b_new = 1'b1;
            end else begin
                if (!route_a_reg[chan_reg] || !cfg.latch_mode) begin
                    ua_new = rv;
                end
                a_new = 1'b1;
                b_new = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            chan_reg    <= '0;
            rng_reg     <= SeedReset;
            route_a_reg <= '0;
            route_b_reg <= '0;
            for (int i = 0; i < MaxChannels; i++) begin
                held_a_reg[i] <= '0;
                held_b_reg[i] <= '0;
                held_e_reg[i] <= '0;
            end
        end else begin
            if (seed.load) begin
                rng_reg <= (seed.value != '0) ? seed.value : SeedReset;
            end else if (issue && job_reg.fire) begin
                rng_reg <= s2;
            end
            if (issue && job_reg.fire) begin
                route_a_reg[chan_reg] <= a_new;
                route_b_reg[chan_reg] <= b_new;
                held_a_reg[chan_reg]  <= ua_new;
                held_b_reg[chan_reg]  <= ub_new;
                held_e_reg[chan_reg]  <= ue_new;
            end
            if (job_pop) begin
                busy_reg <= 1'b1;
                chan_reg <= '0;
            end else if (issue) begin
                if (last) begin
                    busy_reg <= 1'b0;
                end else begin
                    chan_reg <= chan_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (job_pop) begin
            job_reg <= job;
        end
    end

    // pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            p1_valid_reg <= issue;
            p2_valid_reg <= p1_valid_reg;
            m_valid_reg  <= p2_valid_reg;
        end
    end

    assign prod_a = 30'(p1_ua_reg) * 30'(cfg.cv_scale);
    assign prod_b = 30'(p1_ub_reg) * 30'(cfg.cv_scale);
    assign prod_e = 30'(p1_ue_reg) * 30'(cfg.cv_scale);

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_chan_reg   <= chan_reg;
            p1_last_reg   <= last;
            p1_a_gate_reg <= gate_mv(a_new, cfg.latch_mode, job_reg.clk);
            p1_b_gate_reg <= gate_mv(b_new, cfg.latch_mode, job_reg.clk);
            p1_clk_reg    <= job_reg.clk;
            p1_ua_reg     <= ua_new;
            p1_ub_reg     <= ub_new;
            p1_ue_reg     <= ue_new;

            p2_chan_reg   <= p1_chan_reg;
            p2_last_reg   <= p1_last_reg;
            p2_a_gate_reg <= p1_a_gate_reg;
            p2_b_gate_reg <= p1_b_gate_reg;
            p2_clk_reg    <= p1_clk_reg;
            p2_pa_reg     <= prod_a[RandomBits +: 14];
            p2_pb_reg     <= prod_b[RandomBits +: 14];
            p2_pe_reg     <= prod_e[RandomBits +: 14];

            m_res_reg.channel    <= p2_chan_reg;
            m_res_reg.last       <= p2_last_reg;
            m_res_reg.a_gate     <= p2_a_gate_reg;
            m_res_reg.b_gate     <= p2_b_gate_reg;
            m_res_reg.clk        <= p2_clk_reg;
            m_res_reg.a_rand     <= sat15($signed(16'(p2_pa_reg)) + 16'(cfg.cv_offset));
            m_res_reg.b_rand     <= sat15($signed(16'(p2_pb_reg)) + 16'(cfg.cv_offset));
            m_res_reg.every_rand <= sat15($signed(16'(p2_pe_reg)) + 16'(cfg.cv_offset));
        end
    end

    assign out_valid = m_valid_reg;
    assign out_res   = m_res_reg;

endmodule

// ----- design/bernoulli_gate_sample_hold_top.sv -----
`timescale 1ns / 1ps
// Bernoulli gate with sample-and-hold random voltages. Each input transaction is one sample
// tick; it produces one result transaction per active channel (1 to 16), channel 0 first,
// tlast on the final one. The back end emits one channel result per cycle while the result
// stream is not stalled, issued by the channel sequencer and its shared random generator and
// registered through its output pipeline. A two-entry tick queue lets inputs be taken while
// earlier ticks are still being worked off. Configuration writes take effect on the next cycle
// and are meant for idle periods; writing the seed reloads the generator (zero loads as one).
// depends on bgsh_pkg, bgsh_front, bgsh_queue, bgsh_back
module bernoulli_gate_sample_hold_top import bgsh_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // clock_mv[14:0], chance_cv_mv[29:15], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // a_gate_mv, b_gate_mv, a_random_mv, b_random_mv,
                                   // every_random_mv, clock_through_mv, 15 bits each, zero pad
    output logic [3:0]  m_tuser,   // channel
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_data
);

    cfg_t       cfg_reg;
    seed_load_t seed;
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_valid;
    job_t       q_in;
    job_t       q_head;
    result_t    res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.channel_count <= CountW'(1);
            cfg_reg.chance_level  <= '0;
            cfg_reg.cv_scale      <= 14'd10000;
            cfg_reg.cv_offset     <= '0;
            cfg_reg.latch_mode    <= 1'b1;
            cfg_reg.trigger_high  <= 15'sd1000;
            cfg_reg.trigger_low   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                RegChannelCount: cfg_reg.channel_count <= cfg_data[CountW-1:0];
                RegChanceLevel:  cfg_reg.chance_level  <= cfg_data[10:0];
                RegCvScale:      cfg_reg.cv_scale      <= cfg_data[13:0];
                RegCvOffset:     cfg_reg.cv_offset     <= cfg_data[13:0];
                RegLatchMode:    cfg_reg.latch_mode    <= cfg_data[0];
                RegTriggerHigh:  cfg_reg.trigger_high  <= cfg_data[14:0];
                RegTriggerLow:   cfg_reg.trigger_low   <= cfg_data[14:0];
                RegRandomSeed: begin
                end
            endcase
        end
    end

    assign seed.load  = cfg_wr_en && (cfg_reg_t'(cfg_addr) == RegRandomSeed);
    assign seed.value = cfg_data;

    bgsh_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .clock_mv     (s_tdata[14:0]),
        .chance_cv_mv (s_tdata[29:15]),
        .queue_full   (q_full),
        .push         (q_push),
        .job          (q_in)
    );

    bgsh_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    bgsh_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .seed      (seed),
        .job_valid (q_valid),
        .job       (q_head),
        .job_pop   (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {6'b0, res.clk, res.every_rand, res.b_rand, res.a_rand,
                      res.b_gate, res.a_gate};
    assign m_tuser = res.channel;
    assign m_tlast = res.last;

endmodule

// ----- design/bgsh_checker.sv -----
`timescale 1ns / 1ps
// port-level checks on the result stream of the top level, attached by bind
// depends on bgsh_pkg and bernoulli_gate_sample_hold_top
module bgsh_checker import bgsh_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);

    logic [3:0]  exp_chan_reg;
    logic [14:0] a_gate;
    logic [14:0] b_gate;
    logic [14:0] clk_thru;

    assign a_gate   = m_tdata[14:0];
    assign b_gate   = m_tdata[29:15];
    assign clk_thru = m_tdata[89:75];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_chan_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            exp_chan_reg <= m_tlast ? '0 : exp_chan_reg + 1'b1;
        end
    end

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result transaction dropped while stalled");

    a_chan_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser == exp_chan_reg)
        else $error("channel out of sequence within tick");

    a_gate_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (a_gate == '0 || b_gate == '0))
        else $error("both routes gated at once");

    a_gate_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (a_gate == '0 || a_gate == 15'(GateLatchedMv) || a_gate == clk_thru))
        else $error("route a gate level not latched, clock or zero");

endmodule

bind bernoulli_gate_sample_hold_top bgsh_checker u_bgsh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- dv/bernoulli_gate_sample_hold_top_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for bernoulli_gate_sample_hold_top: a behavioral gate model predicts
// every channel result of each tick, checked in order under random stalls on both streams
// depends on bgsh_pkg and bernoulli_gate_sample_hold_top
module bernoulli_gate_sample_hold_top_tb import bgsh_pkg::*;;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_data;

    bernoulli_gate_sample_hold_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    typedef struct packed {
        logic [3:0]  chan;
        logic [14:0] a_gate;
        logic [14:0] b_gate;
        logic [14:0] a_rand;
        logic [14:0] b_rand;
        logic [14:0] every_rand;
        logic [14:0] clk_thru;
        logic        last;
    } chan_result_t;

    chan_result_t owed_results[$];
    int err_count = 0;
    bit tx_gaps = 0;
    bit rx_gaps = 0;
    int sink_hold = 0;

    // gate model: settings
    logic [4:0]         cfg_channels;
    logic signed [10:0] cfg_chance;
    logic [13:0]        cfg_scale;
    logic signed [13:0] cfg_offset;
    logic               cfg_latch;
    logic signed [14:0] cfg_trig_hi;
    logic signed [14:0] cfg_trig_lo;

    // gate model: state
    bit          trig_high;
    bit          route_a_on [16];
    bit          route_b_on [16];
    logic [15:0] hold_a [16];
    logic [15:0] hold_b [16];
    logic [15:0] hold_every [16];
    logic [31:0] rng_state;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic void reset_model();
        cfg_channels = 5'd1;
        cfg_chance   = '0;
        cfg_scale    = 14'd10000;
        cfg_offset   = '0;
        cfg_latch    = 1'b1;
        cfg_trig_hi  = 15'sd1000;
        cfg_trig_lo  = '0;
        trig_high    = 1'b1;
        for (int c = 0; c < 16; c++) begin
            route_a_on[c] = 1'b0;
            route_b_on[c] = 1'b0;
            hold_a[c]     = '0;
            hold_b[c]     = '0;
            hold_every[c] = '0;
        end
        rng_state = 32'd1;
    endfunction

    function automatic void apply_reg(input cfg_reg_t idx, input logic [31:0] val);
        case (idx)
            RegChannelCount: cfg_channels = val[4:0];
            RegChanceLevel:  cfg_chance   = val[10:0];
            RegCvScale:      cfg_scale    = val[13:0];
            RegCvOffset:     cfg_offset   = val[13:0];
            RegLatchMode:    cfg_latch    = val[0];
            RegTriggerHigh:  cfg_trig_hi  = val[14:0];
            RegTriggerLow:   cfg_trig_lo  = val[14:0];
            RegRandomSeed:   rng_state    = (val == '0) ? 32'd1 : val;
            default: ;
        endcase
    endfunction

    function automatic logic [15:0] draw16();
        logic [31:0] s;
        s = rng_state;
        s = s ^ (s << 13);
        s = s ^ (s >> 17);
        s = s ^ (s << 5);
        rng_state = s;
        return s[31:16];
    endfunction

    function automatic logic [14:0] scaled_mv(input logic [15:0] u);
        longint v;
        v = (longint'(u) * longint'(cfg_scale)) >>> 16;
        v = v + longint'(cfg_offset);
        if (v > 16383) v = 16383;
        if (v < -16384) v = -16384;
        return v[14:0];
    endfunction

    function automatic logic [14:0] gate_level(input bit active, input logic [14:0] clk_v);
        if (!active) return '0;
        if (cfg_latch) return 15'd10000;
        return clk_v;
    endfunction

    function automatic void advance_gate_model(input logic signed [14:0] clk_v,
                                               input logic signed [14:0] cv_v);
        int n;
        bit fired;
        longint t;
        logic [15:0] coin;
        logic [15:0] rv;
        chan_result_t r;
        n = cfg_channels;
        if (n < 1) n = 1;
        if (n > 16) n = 16;
        fired = 1'b0;
        if (trig_high) begin
            if (clk_v <= cfg_trig_lo) trig_high = 1'b0;
        end else if (clk_v >= cfg_trig_hi) begin
            trig_high = 1'b1;
            fired = 1'b1;
        end
        if (fired) begin
            t = 5 * longint'(cfg_chance) + longint'(cv_v);
            if (t > 5000) t = 5000;
            if (t < -5000) t = -5000;
            for (int c = 0; c < n; c++) begin
                coin = draw16();
                rv = draw16();
                hold_every[c] = rv;
                if (5000 * (2 * longint'(coin) - 65536) > t * 65536) begin
                    if (!route_b_on[c] || !cfg_latch) hold_b[c] = rv;
                    route_a_on[c] = 1'b0;
                    route_b_on[c] = 1'b1;
                end else begin
                    if (!route_a_on[c] || !cfg_latch) hold_a[c] = rv;
                    route_a_on[c] = 1'b1;
                    route_b_on[c] = 1'b0;
                end
            end
        end
        for (int c = 0; c < n; c++) begin
            r.chan       = 4'(c);
            r.a_gate     = gate_level(route_a_on[c], clk_v);
            r.b_gate     = gate_level(route_b_on[c], clk_v);
            r.a_rand     = scaled_mv(hold_a[c]);
            r.b_rand     = scaled_mv(hold_b[c]);
            r.every_rand = scaled_mv(hold_every[c]);
            r.clk_thru   = clk_v;
            r.last       = (c == n - 1);
            owed_results.push_back(r);
        end
    endfunction

    task automatic note_error(input string msg);
        err_count++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int chan, input logic [14:0] got,
                               input logic [14:0] want);
        if (got !== want)
            note_error($sformatf("ch %0d %s: got %0d, expected %0d", chan, name,
                                 $signed(got), $signed(want)));
    endtask

    always @(posedge aclk) begin : result_check
        chan_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (owed_results.size() == 0) begin
                note_error($sformatf("unexpected transaction on channel %0d", m_tuser));
            end else begin
                want = owed_results.pop_front();
                check_field("channel", want.chan, 15'(m_tuser), 15'(want.chan));
                check_field("a_gate", want.chan, m_tdata[14:0], want.a_gate);
                check_field("b_gate", want.chan, m_tdata[29:15], want.b_gate);
                check_field("a_random", want.chan, m_tdata[44:30], want.a_rand);
                check_field("b_random", want.chan, m_tdata[59:45], want.b_rand);
                check_field("every_random", want.chan, m_tdata[74:60], want.every_rand);
                check_field("clock_through", want.chan, m_tdata[89:75], want.clk_thru);
                check_field("last", want.chan, 15'(m_tlast), 15'(want.last));
            end
        end
    end

    // result sink with per-transaction stalls and an optional long hold-off
    initial begin : result_sink
        int n;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (sink_hold > 0) begin
                n = sink_hold;
                sink_hold = 0;
            end else begin
                n = rx_gaps ? $urandom_range(0, 19) : 0;
            end
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    task automatic send_tick(input int clk_mv, input int cv_mv);
        int gap;
        logic [14:0] c15;
        logic [14:0] v15;
        c15 = 15'(clk_mv);
        v15 = 15'(cv_mv);
        gap = tx_gaps ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {2'b00, v15, c15};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        advance_gate_model(c15, v15);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (owed_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        apply_reg(idx, val);
    endtask

    task automatic load_settings(input int ch, input int chance, input int scale,
                                 input int offset, input int latch, input int hi,
                                 input int lo, input logic [31:0] seed);
        write_reg(RegChannelCount, 32'(ch));
        write_reg(RegChanceLevel, 32'(chance));
        write_reg(RegCvScale, 32'(scale));
        write_reg(RegCvOffset, 32'(offset));
        write_reg(RegLatchMode, 32'(latch));
        write_reg(RegTriggerHigh, 32'(hi));
        write_reg(RegTriggerLow, 32'(lo));
        write_reg(RegRandomSeed, seed);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_reset_trigger();
        tx_gaps = 0;
        rx_gaps = 0;
        send_tick(2000, 0);         // trigger starts high, no edge
        send_tick(-12000, 12000);
        send_tick(12000, -12000);
        send_tick(999, 0);
        send_tick(0, 0);            // re-arms exactly at the low level
        send_tick(1000, 0);         // fires exactly at the high level
        wait_drained();
    endtask

    task automatic test_extremes();
        tx_gaps = 1;
        rx_gaps = 0;
        // zero span, lowest offset, passthrough gates, zero seed
        load_settings(16, -1000, 0, -8192, 0, 1000, 0, 32'd0);
        send_tick(0, 0);
        send_tick(16383, 16383);
        send_tick(-16384, -16384);
        send_tick(1000, 12000);
        wait_drained();
        // count above range, widest span with highest offset saturates, latched
        tx_gaps = 0;
        rx_gaps = 1;
        load_settings(31, 1000, 16383, 8191, 1, 1000, 0, 32'hFFFF_FFFF);
        send_tick(0, -12000);
        send_tick(5000, -12000);
        send_tick(0, 0);
        send_tick(5000, 0);
        send_tick(0, 12000);
        send_tick(5000, 12000);
        wait_drained();
    endtask

    task automatic test_crossed_levels();
        tx_gaps = 1;
        rx_gaps = 1;
        // zero channel count runs one channel; low level above high level
        load_settings(0, 0, 10000, 0, 1, -500, 500, 32'd12345);
        repeat (4) send_tick(0, 0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        tx_gaps = 0;
        rx_gaps = 0;
        load_settings(16, 0, 10000, 0, 1, 1000, 0, $urandom);
        sink_hold = 400;
        for (int i = 0; i < 20; i++) begin
            if (i[0]) send_tick($urandom_range(1000, 12000), $urandom_range(0, 24000) - 12000);
            else send_tick(-int'($urandom_range(0, 12000)), $urandom_range(0, 24000) - 12000);
        end
        wait_drained();
    endtask

    task automatic pick_random_settings();
        int ch;
        int chance;
        int scale;
        int offset;
        int hi;
        int lo;
        ch = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
        chance = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 2000) - 1000;
        scale = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 10000);
        offset = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 10000) - 5000;
        hi = $urandom_range(0, 24000) - 12000;
        if ($urandom_range(0, 5) == 0) lo = hi + $urandom_range(0, 2000);
        else lo = hi - $urandom_range(0, 4000);
        if (lo < -16384) lo = -16384;
        if (lo > 16383) lo = 16383;
        load_settings(ch, chance, scale, offset, $urandom_range(0, 1), hi, lo, $urandom);
    endtask

    task automatic random_ticks(input int count);
        bit high_phase;
        int clk_v;
        int cv_v;
        high_phase = 1'b0;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) < 8) begin
                high_phase = !high_phase;
                if (high_phase) begin
                    clk_v = cfg_trig_hi + int'($urandom_range(0, 1500));
                    if (clk_v > 16383) clk_v = 16383;
                end else begin
                    clk_v = cfg_trig_lo - int'($urandom_range(0, 1500));
                    if (clk_v < -16384) clk_v = -16384;
                end
            end else begin
                clk_v = $urandom;
            end
            if ($urandom_range(0, 3) == 0) cv_v = $urandom;
            else cv_v = $urandom_range(0, 24000) - 12000;
            send_tick(clk_v, cv_v);
            if ($urandom_range(0, 39) == 0) wait_drained();
        end
        wait_drained();
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < 5; p++) begin
            tx_gaps = (p == 1 || p >= 3);
            rx_gaps = (p >= 2);
            pick_random_settings();
            random_ticks(46);
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= RegChannelCount;
        cfg_data  <= '0;
        reset_model();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_trigger();
        test_extremes();
        test_crossed_levels();
        test_backpressure();
        test_random_phases();

        wait_drained();
        repeat (40) @(posedge aclk);
        if (owed_results.size() != 0)
            note_error($sformatf("%0d results never arrived", owed_results.size()));
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
